### rtl/core/ile_pkg.sv
// shared types and constants for the indexed list engine
// no dependencies

package ile_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W = 4;
  localparam int OUT_CNT_W = 5;
  localparam int OUT_POS_W = 5;
  localparam int DEFAULT_CAPACITY = 16;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_READ   = 3'd3,
    OP_SEARCH = 3'd4,
    OP_SWAP   = 3'd5,
    OP_CLEAR  = 3'd6
  } op_t;

  typedef struct packed {
    logic              update;
    op_t               op;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  pos2;
    logic [DATA_W-1:0] val;
  } cell_cmd_t;

endpackage

### rtl/core/ile_if.sv
// valid/ready channel interfaces for command and response words
// depends on ile_pkg

interface ile_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          operation;
  logic [ile_pkg::POS_W-1:0]           index;
  logic [ile_pkg::POS_W-1:0]           second_index;
  logic signed [ile_pkg::DATA_W-1:0]   value;

  modport source (output valid, operation, index, second_index, value, input ready);
  modport sink (input valid, operation, index, second_index, value, output ready);
endinterface

interface ile_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   ok;
  logic signed [ile_pkg::DATA_W-1:0]      read_value;
  logic signed [ile_pkg::OUT_POS_W-1:0]   found_position;
  logic [ile_pkg::OUT_CNT_W-1:0]          entry_count;

  modport source (output valid, ok, read_value, found_position, entry_count, input ready);
  modport sink (input valid, ok, read_value, found_position, entry_count, output ready);
endinterface

### rtl/core/ile_cell.sv
// one list position: holds an entry, shifts to or from its neighbours,
// compares against the search word; depends on ile_pkg

module ile_cell #(
  parameter int CAPACITY = ile_pkg::DEFAULT_CAPACITY,
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  ile_pkg::cell_cmd_t                 cmd,
  input  logic [$clog2(CAPACITY+1)-1:0]      count,
  input  logic [ile_pkg::DATA_W-1:0]         left,
  input  logic [ile_pkg::DATA_W-1:0]         right,
  input  logic [ile_pkg::DATA_W-1:0]         swap_a,
  input  logic [ile_pkg::DATA_W-1:0]         swap_b,
  input  logic                               seen_in,
  output logic [ile_pkg::DATA_W-1:0]         data,
  output logic                               seen_out,
  output logic [ile_pkg::DATA_W-1:0]         rd_a,
  output logic [ile_pkg::DATA_W-1:0]         rd_b,
  output logic [ile_pkg::OUT_POS_W-1:0]      found_bits
);

  localparam int CW = $clog2(CAPACITY+1);
  localparam int EW = ((CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W) + 1;
  localparam logic [EW-1:0] ME = EW'(IDX);
  localparam logic [EW-1:0] ME_UP = EW'(IDX + 1);

  logic [ile_pkg::DATA_W-1:0] data_next;
  logic [EW-1:0] pos_e;
  logic [EW-1:0] pos2_e;
  logic [EW-1:0] cnt_e;
  logic hit;
  logic at_a;
  logic at_b;

  assign pos_e  = {{(EW-ile_pkg::POS_W){1'b0}}, cmd.pos};
  assign pos2_e = {{(EW-ile_pkg::POS_W){1'b0}}, cmd.pos2};
  assign cnt_e  = {{(EW-CW){1'b0}}, count};
  assign at_a   = (ME == pos_e);
  assign at_b   = (ME == pos2_e);

  // first match along the chain
  assign hit        = (ME < cnt_e) && (data == cmd.val);
  assign seen_out   = seen_in | hit;
  assign found_bits = (hit && !seen_in) ? ile_pkg::OUT_POS_W'(IDX) : '0;

  assign rd_a = at_a ? data : '0;
  assign rd_b = at_b ? data : '0;

  always_comb begin
    data_next = data;
    if (cmd.update) begin
      case (cmd.op)
        ile_pkg::OP_APPEND: begin
          if (ME == cnt_e) data_next = cmd.val;
        end
        ile_pkg::OP_INSERT: begin
          if (at_a) begin
            data_next = cmd.val;
          end else if ((ME > pos_e) && (ME <= cnt_e)) begin
            data_next = left;
          end
        end
        ile_pkg::OP_REMOVE: begin
          if ((ME >= pos_e) && (ME_UP < cnt_e)) data_next = right;
        end
        ile_pkg::OP_SWAP: begin
          if (at_a) begin
            data_next = swap_b;
          end else if (at_b) begin
            data_next = swap_a;
          end
        end
        default: begin
          data_next = data;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

### rtl/core/indexed_list_engine_top.sv
// Ordered list of signed 32-bit entries held in a row of cells, one entry per
// cell. Every command (append, insert, remove, read, search, swap, clear)
// is carried out when its word is accepted and returns one response word; a new
// command word is taken each cycle that the response register is empty or being
// drained, so throughput is one command per cycle. The cycle length is set by
// the search path: each cell compares its entry and the first-match flag
// ripples along the whole row. Only the first 16 positions are addressable.
// Depends on ile_pkg, ile_if and ile_cell.

module indexed_list_engine_top #(
  parameter int CAPACITY = ile_pkg::DEFAULT_CAPACITY
) (
  input  logic           clk,
  input  logic           rst,
  ile_cmd_if.sink        cmd,
  ile_rsp_if.source      rsp
);

  localparam int CW = $clog2(CAPACITY+1);
  localparam int EW = ((CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W) + 1;
  localparam logic [EW-1:0] CAP_E = EW'(CAPACITY);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic accept;
  logic ok;
  ile_pkg::op_t op;
  ile_pkg::cell_cmd_t cell_cmd;
  logic [EW-1:0] pos_e;
  logic [EW-1:0] pos2_e;
  logic [EW-1:0] cnt_e;

  logic [ile_pkg::DATA_W-1:0] cell_data [CAPACITY];
  logic [ile_pkg::DATA_W-1:0] cell_rd_a [CAPACITY];
  logic [ile_pkg::DATA_W-1:0] cell_rd_b [CAPACITY];
  logic [ile_pkg::OUT_POS_W-1:0] cell_found [CAPACITY];
  logic [CAPACITY:0] seen;

  logic [ile_pkg::DATA_W-1:0] word_a;
  logic [ile_pkg::DATA_W-1:0] word_b;
  logic [ile_pkg::OUT_POS_W-1:0] found_any;

  logic res_valid;
  logic res_ok;
  logic [ile_pkg::DATA_W-1:0] res_read;
  logic [ile_pkg::OUT_POS_W-1:0] res_found;
  logic [ile_pkg::OUT_CNT_W-1:0] res_count;
  logic [ile_pkg::DATA_W-1:0] read_next;
  logic [ile_pkg::OUT_POS_W-1:0] found_next;

  assign op     = ile_pkg::op_t'(cmd.operation);
  assign pos_e  = {{(EW-ile_pkg::POS_W){1'b0}}, cmd.index};
  assign pos2_e = {{(EW-ile_pkg::POS_W){1'b0}}, cmd.second_index};
  assign cnt_e  = {{(EW-CW){1'b0}}, count};

  assign cmd.ready = !res_valid || rsp.ready;
  assign accept    = cmd.valid && cmd.ready;

  assign cell_cmd.update = accept && ok;
  assign cell_cmd.op     = op;
  assign cell_cmd.pos    = cmd.index;
  assign cell_cmd.pos2   = cmd.second_index;
  assign cell_cmd.val    = cmd.value;

  assign seen[0] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [ile_pkg::DATA_W-1:0] left_w;
      logic [ile_pkg::DATA_W-1:0] right_w;
      if (g == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = cell_data[g-1];
      end
      if (g == CAPACITY-1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = cell_data[g+1];
      end
      ile_cell #(
        .CAPACITY (CAPACITY),
        .IDX      (g)
      ) u_cell (
        .clk        (clk),
        .cmd        (cell_cmd),
        .count      (count),
        .left       (left_w),
        .right      (right_w),
        .swap_a     (word_a),
        .swap_b     (word_b),
        .seen_in    (seen[g]),
        .data       (cell_data[g]),
        .seen_out   (seen[g+1]),
        .rd_a       (cell_rd_a[g]),
        .rd_b       (cell_rd_b[g]),
        .found_bits (cell_found[g])
      );
    end
  endgenerate

  // read buses
  always_comb begin
    word_a    = '0;
    word_b    = '0;
    found_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      word_a    = word_a | cell_rd_a[i];
      word_b    = word_b | cell_rd_b[i];
      found_any = found_any | cell_found[i];
    end
  end

  always_comb begin
    ok         = 1'b0;
    count_next = count;
    read_next  = '0;
    found_next = '1;
    case (op)
      ile_pkg::OP_APPEND: begin
        ok = (cnt_e < CAP_E);
        if (ok) count_next = count + 1'b1;
      end
      ile_pkg::OP_INSERT: begin
        ok = (cnt_e < CAP_E) && (pos_e <= cnt_e);
        if (ok) count_next = count + 1'b1;
      end
      ile_pkg::OP_REMOVE: begin
        ok = (pos_e < cnt_e);
        if (ok) count_next = count - 1'b1;
      end
      ile_pkg::OP_READ: begin
        ok        = (pos_e < cnt_e);
        read_next = ok ? word_a : '1;
      end
      ile_pkg::OP_SEARCH: begin
        ok = seen[CAPACITY];
        if (ok) found_next = found_any;
      end
      ile_pkg::OP_SWAP: begin
        ok = (pos_e < cnt_e) && (pos2_e < cnt_e);
      end
      ile_pkg::OP_CLEAR: begin
        ok         = 1'b1;
        count_next = '0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // response word
  always_ff @(posedge clk) begin
    if (accept) begin
      res_ok    <= ok;
      res_read  <= read_next;
      res_found <= found_next;
      res_count <= ile_pkg::OUT_CNT_W'(count_next);
    end
  end

  assign rsp.valid          = res_valid;
  assign rsp.ok             = res_ok;
  assign rsp.read_value     = res_read;
  assign rsp.found_position = res_found;
  assign rsp.entry_count    = res_count;

endmodule

### bench/testbench.sv
// self-checking bench for indexed_list_engine_top: random and directed command words
// with a list predictor and in-order response checking
// depends on ile_pkg, ile_cmd_if, ile_rsp_if and the engine rtl
`timescale 1ns / 100ps

module testbench;

  localparam int LIST_DEPTH = 16;
  localparam int PHASE_WORDS = 132;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef struct {
    logic [2:0]                        operation;
    logic [ile_pkg::POS_W-1:0]         index;
    logic [ile_pkg::POS_W-1:0]         second_index;
    logic signed [ile_pkg::DATA_W-1:0] value;
  } list_cmd_t;

  typedef struct {
    logic                                 ok;
    logic signed [ile_pkg::DATA_W-1:0]    read_value;
    logic signed [ile_pkg::OUT_POS_W-1:0] found_position;
    logic [ile_pkg::OUT_CNT_W-1:0]        entry_count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ile_cmd_if cmd ();
  ile_rsp_if rsp ();

  indexed_list_engine_top #(.CAPACITY(LIST_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp)
  );

  always #1 clk = ~clk;

  list_cmd_t    pending_words[$];
  list_result_t expected_results[$];
  logic [ile_pkg::DATA_W-1:0] list_entries[LIST_DEPTH];
  int list_count = 0;
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // stimulus-side tracking of the count, used to steer positions into range
  int gen_count = 0;
  bit filling = 1'b1;
  logic [ile_pkg::DATA_W-1:0] value_pool[8];

  function automatic list_result_t apply_list_command(input list_cmd_t c);
    list_result_t r;
    logic [ile_pkg::DATA_W-1:0] held;
    int i;
    r.ok = 1'b0;
    r.read_value = '0;
    r.found_position = '1;
    case (c.operation)
      ile_pkg::OP_APPEND: begin
        if (list_count < LIST_DEPTH) begin
          list_entries[list_count] = c.value;
          list_count++;
          r.ok = 1'b1;
        end
      end
      ile_pkg::OP_INSERT: begin
        if (list_count < LIST_DEPTH && int'(c.index) <= list_count) begin
          for (i = list_count; i > int'(c.index); i--) list_entries[i] = list_entries[i-1];
          list_entries[c.index] = c.value;
          list_count++;
          r.ok = 1'b1;
        end
      end
      ile_pkg::OP_REMOVE: begin
        if (int'(c.index) < list_count) begin
          for (i = int'(c.index); i + 1 < list_count; i++) list_entries[i] = list_entries[i+1];
          list_count--;
          r.ok = 1'b1;
        end
      end
      ile_pkg::OP_READ: begin
        if (int'(c.index) < list_count) begin
          r.read_value = list_entries[c.index];
          r.ok = 1'b1;
        end else begin
          r.read_value = '1;
        end
      end
      ile_pkg::OP_SEARCH: begin
        for (i = 0; i < list_count && !r.ok; i++) begin
          if (list_entries[i] == c.value) begin
            r.found_position = i[ile_pkg::OUT_POS_W-1:0];
            r.ok = 1'b1;
          end
        end
      end
      ile_pkg::OP_SWAP: begin
        if (int'(c.index) < list_count && int'(c.second_index) < list_count) begin
          held = list_entries[c.index];
          list_entries[c.index] = list_entries[c.second_index];
          list_entries[c.second_index] = held;
          r.ok = 1'b1;
        end
      end
      ile_pkg::OP_CLEAR: begin
        list_count = 0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.entry_count = list_count[ile_pkg::OUT_CNT_W-1:0];
    return r;
  endfunction

  task automatic queue_command(input logic [2:0] op, input int idx, input int idx2,
                               input logic [ile_pkg::DATA_W-1:0] val);
    list_cmd_t c;
    c.operation = op;
    c.index = idx[ile_pkg::POS_W-1:0];
    c.second_index = idx2[ile_pkg::POS_W-1:0];
    c.value = val;
    pending_words.push_back(c);
    case (op)
      ile_pkg::OP_APPEND: if (gen_count < LIST_DEPTH) gen_count++;
      ile_pkg::OP_INSERT: if (gen_count < LIST_DEPTH && idx <= gen_count) gen_count++;
      ile_pkg::OP_REMOVE: if (idx < gen_count) gen_count--;
      ile_pkg::OP_CLEAR:  gen_count = 0;
      default: ;
    endcase
  endtask

  function automatic int pick_position(input int upper);
    if (upper > 0 && $urandom_range(0, 99) < 85) return $urandom_range(0, upper - 1);
    return $urandom_range(0, LIST_DEPTH - 1);
  endfunction

  function automatic logic [ile_pkg::DATA_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 55) return value_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  task automatic queue_random_command();
    int roll;
    logic [2:0] op;
    roll = $urandom_range(0, 99);
    if (gen_count == LIST_DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
    if (gen_count == 0) filling = 1'b1;
    if (filling) begin
      if (roll < 33) op = ile_pkg::OP_APPEND;
      else if (roll < 55) op = ile_pkg::OP_INSERT;
      else if (roll < 62) op = ile_pkg::OP_REMOVE;
      else if (roll < 74) op = ile_pkg::OP_READ;
      else if (roll < 87) op = ile_pkg::OP_SEARCH;
      else if (roll < 97) op = ile_pkg::OP_SWAP;
      else if (roll < 98) op = ile_pkg::OP_CLEAR;
      else op = OP_UNUSED;
    end else begin
      if (roll < 8) op = ile_pkg::OP_APPEND;
      else if (roll < 16) op = ile_pkg::OP_INSERT;
      else if (roll < 48) op = ile_pkg::OP_REMOVE;
      else if (roll < 62) op = ile_pkg::OP_READ;
      else if (roll < 78) op = ile_pkg::OP_SEARCH;
      else if (roll < 92) op = ile_pkg::OP_SWAP;
      else if (roll < 96) op = ile_pkg::OP_CLEAR;
      else op = OP_UNUSED;
    end
    if (op == ile_pkg::OP_INSERT)
      queue_command(op, pick_position(gen_count + 1), 0, pick_value());
    else
      queue_command(op, pick_position(gen_count), pick_position(gen_count), pick_value());
  endtask

  task automatic queue_directed_words();
    queue_command(ile_pkg::OP_READ, 0, 0, 0);
    queue_command(ile_pkg::OP_SEARCH, 0, 0, 0);
    queue_command(ile_pkg::OP_REMOVE, 0, 0, 0);
    queue_command(ile_pkg::OP_SWAP, 0, 0, 0);
    queue_command(ile_pkg::OP_APPEND, 0, 0, 32'h8000_0000);
    queue_command(ile_pkg::OP_APPEND, 0, 0, 32'h7fff_ffff);
    queue_command(ile_pkg::OP_APPEND, 0, 0, 32'hffff_ffff);
    queue_command(ile_pkg::OP_APPEND, 0, 0, 32'h0000_0000);
    queue_command(ile_pkg::OP_INSERT, 0, 0, 32'h1234_5678);
    queue_command(ile_pkg::OP_INSERT, 5, 0, 32'hffff_ffff);
    queue_command(ile_pkg::OP_INSERT, 15, 15, 32'h0000_0005);
    queue_command(ile_pkg::OP_READ, 0, 0, 0);
    queue_command(ile_pkg::OP_READ, 5, 0, 0);
    queue_command(ile_pkg::OP_READ, 15, 0, 0);
    queue_command(ile_pkg::OP_SEARCH, 0, 0, 32'hffff_ffff);
    queue_command(ile_pkg::OP_SEARCH, 0, 0, 32'h5555_5555);
    queue_command(ile_pkg::OP_SWAP, 2, 2, 0);
    queue_command(ile_pkg::OP_SWAP, 0, 5, 0);
    queue_command(ile_pkg::OP_SWAP, 1, 14, 0);
    queue_command(ile_pkg::OP_REMOVE, 5, 0, 0);
    queue_command(ile_pkg::OP_REMOVE, 0, 0, 0);
    queue_command(OP_UNUSED, 3, 9, 32'hdead_beef);
    queue_command(ile_pkg::OP_CLEAR, 15, 15, 32'hffff_ffff);
    queue_command(ile_pkg::OP_READ, 0, 0, 0);
    queue_command(ile_pkg::OP_APPEND, 0, 0, 32'h0000_0001);
  endtask

  // sampled mid-cycle so the edge updates have settled
  task automatic wait_until_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || cmd.valid || expected_results.size() != 0);
  endtask

  initial begin
    cmd.valid = 1'b0;
    cmd.operation = '0;
    cmd.index = '0;
    cmd.second_index = '0;
    cmd.value = '0;
    rsp.ready = 1'b0;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      if (phase == 0) queue_directed_words();
      for (int n = 0; n < PHASE_WORDS; n++) queue_random_command();
      wait_until_idle();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin
    list_cmd_t w;
    if (rst) begin
      cmd.valid <= 1'b0;
    end else if (!cmd.valid || cmd.ready) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        w = pending_words.pop_front();
        cmd.valid <= 1'b1;
        cmd.operation <= w.operation;
        cmd.index <= w.index;
        cmd.second_index <= w.second_index;
        cmd.value <= w.value;
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // responses are checked before the word taken on this edge is predicted
  always @(posedge clk) begin
    list_cmd_t c;
    list_result_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        $error("response word with nothing expected");
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (rsp.ok !== e.ok) begin
          $error("ok: expected %0d, got %0d", e.ok, rsp.ok);
          error_count++;
        end
        if (rsp.read_value !== e.read_value) begin
          $error("read_value: expected %0d, got %0d", e.read_value, rsp.read_value);
          error_count++;
        end
        if (rsp.found_position !== e.found_position) begin
          $error("found_position: expected %0d, got %0d", e.found_position, rsp.found_position);
          error_count++;
        end
        if (rsp.entry_count !== e.entry_count) begin
          $error("entry_count: expected %0d, got %0d", e.entry_count, rsp.entry_count);
          error_count++;
        end
      end
    end
    if (!rst && cmd.valid && cmd.ready) begin
      c.operation = cmd.operation;
      c.index = cmd.index;
      c.second_index = cmd.second_index;
      c.value = cmd.value;
      expected_results.push_back(apply_list_command(c));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

### sim.f
rtl/core/ile_pkg.sv
rtl/core/ile_if.sv
rtl/core/ile_cell.sv
rtl/core/indexed_list_engine_top.sv
bench/testbench.sv
